[sv/rpfp_pkg.sv]
// shared types and constants for the rgb pixel format packer
package rpfp_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned MAX_W   = 16;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned PROD_W  = LEVEL_W + MAX_W;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned ADDR_W  = 5;

  // rounding bias and reciprocal of 255, exact for every product below 2**31 / 127
  localparam logic [PROD_W-1:0] RND_BIAS    = PROD_W'(127);
  localparam logic [PROD_W-1:0] RECIP_MUL   = 24'h808081;
  localparam int unsigned       RECIP_SHIFT = 31;

  localparam logic [2:0] REG_RED_MAX     = 3'd0;
  localparam logic [2:0] REG_GREEN_MAX   = 3'd1;
  localparam logic [2:0] REG_BLUE_MAX    = 3'd2;
  localparam logic [2:0] REG_RED_SHIFT   = 3'd3;
  localparam logic [2:0] REG_GREEN_SHIFT = 3'd4;
  localparam logic [2:0] REG_BLUE_SHIFT  = 3'd5;
  localparam logic [2:0] REG_BIG_ENDIAN  = 3'd6;
  localparam logic [2:0] REG_PIXEL_SIZE  = 3'd7;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_NONE = 3'd0;
  localparam logic [COUNT_W-1:0] COUNT_8    = 3'd1;
  localparam logic [COUNT_W-1:0] COUNT_16   = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_32   = 3'd4;

  localparam logic [MAX_W-1:0]   RST_MAX         = 16'd255;
  localparam logic [SHIFT_W-1:0] RST_RED_SHIFT   = 5'd16;
  localparam logic [SHIFT_W-1:0] RST_GREEN_SHIFT = 5'd8;
  localparam logic [SHIFT_W-1:0] RST_BLUE_SHIFT  = 5'd0;
  localparam logic [1:0]         RST_PIXEL_SIZE  = SIZE_32;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

[sv/rgb_pixel_format_packer_unit.sv]
// top level of the rgb pixel format packer: config registers, scalers and packing stage
//
// Takes one 8-bit red, green and blue sample per transfer and returns the packed
// framebuffer bytes, first byte in bits 7:0, with the number of valid bytes (1, 2, 4,
// or 0 for the unsupported size). One pixel is accepted every clock cycle unless
// in_stall is high; the stages are the component multiply, the divide by 255 done as a
// multiply by its reciprocal, and the shift, merge and byte ordering stage. Each
// stage holds its item under out_stall and fills bubbles, so in_stall rises only
// when all three stages are full and the output is stalled. Registers sit at byte
// address 4*index and are to be written only while the pipeline is empty.
module rgb_pixel_format_packer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rpfp_pkg::LEVEL_W-1:0]     in_red_level,
  input  logic [rpfp_pkg::LEVEL_W-1:0]     in_green_level,
  input  logic [rpfp_pkg::LEVEL_W-1:0]     in_blue_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rpfp_pkg::WORD_W-1:0]      out_packed_bytes,
  output logic [rpfp_pkg::COUNT_W-1:0]     out_byte_count,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rpfp_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import rpfp_pkg::*;

  logic [MAX_W-1:0]   red_max_r;
  logic [MAX_W-1:0]   green_max_r;
  logic [MAX_W-1:0]   blue_max_r;
  logic [SHIFT_W-1:0] red_shift_r;
  logic [SHIFT_W-1:0] green_shift_r;
  logic [SHIFT_W-1:0] blue_shift_r;
  logic               big_endian_r;
  logic [1:0]         pixel_size_r;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  logic               v1_r, v2_r, v3_r;
  logic               v1_nxt, v2_nxt, v3_nxt;
  logic               adv1, adv2, adv3;
  stage_en_t          scale_en;

  logic [MAX_W-1:0]   red_scaled, green_scaled, blue_scaled;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  packed_r, packed_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_max_r     <= RST_MAX;
      green_max_r   <= RST_MAX;
      blue_max_r    <= RST_MAX;
      red_shift_r   <= RST_RED_SHIFT;
      green_shift_r <= RST_GREEN_SHIFT;
      blue_shift_r  <= RST_BLUE_SHIFT;
      big_endian_r  <= 1'b0;
      pixel_size_r  <= RST_PIXEL_SIZE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RED_MAX:     red_max_r     <= pwdata[MAX_W-1:0];
        REG_GREEN_MAX:   green_max_r   <= pwdata[MAX_W-1:0];
        REG_BLUE_MAX:    blue_max_r    <= pwdata[MAX_W-1:0];
        REG_RED_SHIFT:   red_shift_r   <= pwdata[SHIFT_W-1:0];
        REG_GREEN_SHIFT: green_shift_r <= pwdata[SHIFT_W-1:0];
        REG_BLUE_SHIFT:  blue_shift_r  <= pwdata[SHIFT_W-1:0];
        REG_BIG_ENDIAN:  big_endian_r  <= pwdata[0];
        REG_PIXEL_SIZE:  pixel_size_r  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RED_MAX:     prdata = 32'(red_max_r);
      REG_GREEN_MAX:   prdata = 32'(green_max_r);
      REG_BLUE_MAX:    prdata = 32'(blue_max_r);
      REG_RED_SHIFT:   prdata = 32'(red_shift_r);
      REG_GREEN_SHIFT: prdata = 32'(green_shift_r);
      REG_BLUE_SHIFT:  prdata = 32'(blue_shift_r);
      REG_BIG_ENDIAN:  prdata = 32'(big_endian_r);
      REG_PIXEL_SIZE:  prdata = 32'(pixel_size_r);
      default:         prdata = '0;
    endcase
  end

  // pipeline flow: a stage moves when empty or when the next one moves
  assign adv3     = !v3_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  assign scale_en.s1 = adv1;
  assign scale_en.s2 = adv2;

  assign v1_nxt = adv1 ? in_valid : v1_r;
  assign v2_nxt = adv2 ? v1_r : v2_r;
  assign v3_nxt = adv3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  rpfp_scale u_scale_red (
    .clk       (clk),
    .en        (scale_en),
    .level     (in_red_level),
    .level_max (red_max_r),
    .scaled    (red_scaled)
  );

  rpfp_scale u_scale_green (
    .clk       (clk),
    .en        (scale_en),
    .level     (in_green_level),
    .level_max (green_max_r),
    .scaled    (green_scaled)
  );

  rpfp_scale u_scale_blue (
    .clk       (clk),
    .en        (scale_en),
    .level     (in_blue_level),
    .level_max (blue_max_r),
    .scaled    (blue_scaled)
  );

  // merge and byte ordering
  assign word = (WORD_W'(red_scaled) << red_shift_r) |
                (WORD_W'(green_scaled) << green_shift_r) |
                (WORD_W'(blue_scaled) << blue_shift_r);

  always_comb begin
    case (pixel_size_r)
      SIZE_32: begin
        count_nxt = COUNT_32;
        if (big_endian_r) begin
          packed_nxt = {word[7:0], word[15:8], word[23:16], word[31:24]};
        end else begin
          packed_nxt = word;
        end
      end
      SIZE_16: begin
        count_nxt = COUNT_16;
        if (big_endian_r) begin
          packed_nxt = {16'd0, word[7:0], word[15:8]};
        end else begin
          packed_nxt = {16'd0, word[15:0]};
        end
      end
      SIZE_8: begin
        count_nxt  = COUNT_8;
        packed_nxt = {24'd0, red_scaled[7:0]};
      end
      default: begin
        count_nxt  = COUNT_NONE;
        packed_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      packed_r <= packed_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_valid        = v3_r;
  assign out_packed_bytes = packed_r;
  assign out_byte_count   = count_r;

`ifndef SYNTHESIS
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count == COUNT_NONE || out_byte_count == COUNT_8 ||
                   out_byte_count == COUNT_16 || out_byte_count == COUNT_32))
    else $error("illegal byte count");

  a_byte_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_count == COUNT_8) |-> (out_packed_bytes[31:8] == 24'd0))
    else $error("single byte result has upper bits set");

  a_half_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_count == COUNT_16) |-> (out_packed_bytes[31:16] == 16'd0))
    else $error("two byte result has upper bits set");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> !in_stall)
    else $error("input stalled with an empty first stage");
`endif

endmodule

[sv/rpfp_scale.sv]
// two-stage scaler of one colour component: multiply with bias, then divide by 255
module rpfp_scale (
  input  logic                      clk,
  input  rpfp_pkg::stage_en_t       en,
  input  logic [rpfp_pkg::LEVEL_W-1:0] level,
  input  logic [rpfp_pkg::MAX_W-1:0]   level_max,
  output logic [rpfp_pkg::MAX_W-1:0]   scaled
);
  import rpfp_pkg::*;

  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   prod_nxt;
  logic [2*PROD_W-1:0] recip_prod;
  logic [MAX_W-1:0]    quot_r;
  logic [MAX_W-1:0]    quot_nxt;

  // a zero maximum leaves only the bias, which divides to zero
  assign prod_nxt   = PROD_W'(level) * PROD_W'(level_max) + RND_BIAS;
  assign recip_prod = (2*PROD_W)'(prod_r) * (2*PROD_W)'(RECIP_MUL);
  assign quot_nxt   = recip_prod[RECIP_SHIFT +: MAX_W];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r <= prod_nxt;
    end
    if (en.s2) begin
      quot_r <= quot_nxt;
    end
  end

  assign scaled = quot_r;

endmodule

[bench/tb_rgb_pixel_format_packer_unit.sv]
// self-checking testbench for the rgb pixel format packer with a bit-exact packing predictor
module tb_rgb_pixel_format_packer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rpfp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int SWEEP_PHASES = 13;
  localparam int PHASE_PIXELS = 50;

  typedef struct packed {
    logic [WORD_W-1:0]  bytes;
    logic [COUNT_W-1:0] count;
  } packed_pixel_t;

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [LEVEL_W-1:0]   in_red_level   = '0;
  logic [LEVEL_W-1:0]   in_green_level = '0;
  logic [LEVEL_W-1:0]   in_blue_level  = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [WORD_W-1:0]    out_packed_bytes;
  logic [COUNT_W-1:0]   out_byte_count;
  logic                 psel           = 1'b0;
  logic                 penable        = 1'b0;
  logic                 pwrite         = 1'b0;
  logic [ADDR_W-1:0]    paddr          = '0;
  logic [31:0]          pwdata         = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // format mirror, index 0 red, 1 green, 2 blue
  logic [MAX_W-1:0]   level_max [3]   = '{RST_MAX, RST_MAX, RST_MAX};
  logic [SHIFT_W-1:0] level_shift [3] = '{RST_RED_SHIFT, RST_GREEN_SHIFT, RST_BLUE_SHIFT};
  logic               byte_swap       = 1'b0;
  logic [1:0]         pixel_size      = RST_PIXEL_SIZE;

  packed_pixel_t packed_queue [$];
  int            mismatches = 0;
  int            cycles     = 0;
  int            idle_pct   = 20;

  rgb_pixel_format_packer_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red_level     (in_red_level),
    .in_green_level   (in_green_level),
    .in_blue_level    (in_blue_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packed_bytes (out_packed_bytes),
    .out_byte_count   (out_byte_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[rgb_pixel_format_packer_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (idle_pct != 0) && ($urandom_range(0, 99) < idle_pct);
  end

  function automatic packed_pixel_t pack_pixel(input logic [LEVEL_W-1:0] red,
                                               input logic [LEVEL_W-1:0] green,
                                               input logic [LEVEL_W-1:0] blue);
    logic [31:0]        scaled [3];
    logic [LEVEL_W-1:0] lvl [3];
    logic [WORD_W-1:0]  word;
    packed_pixel_t      res;
    lvl[0] = red;
    lvl[1] = green;
    lvl[2] = blue;
    for (int c = 0; c < 3; c++) begin
      if (level_max[c] == '0) begin
        scaled[c] = 32'd0;
      end else begin
        scaled[c] = (32'(lvl[c]) * 32'(level_max[c]) + 32'd127) / 32'd255;
      end
    end
    word = (scaled[0] << level_shift[0]) | (scaled[1] << level_shift[1]) |
           (scaled[2] << level_shift[2]);
    res = '0;
    case (pixel_size)
      SIZE_32: begin
        res.bytes = byte_swap ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
        res.count = COUNT_32;
      end
      SIZE_16: begin
        res.bytes = byte_swap ? {16'd0, word[7:0], word[15:8]} : {16'd0, word[15:0]};
        res.count = COUNT_16;
      end
      SIZE_8: begin
        res.bytes = {24'd0, scaled[0][7:0]};
        res.count = COUNT_8;
      end
      default: begin
        res.count = COUNT_NONE;
      end
    endcase
    return res;
  endfunction

  function automatic void note_register(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      REG_RED_MAX:     level_max[0]   = value[MAX_W-1:0];
      REG_GREEN_MAX:   level_max[1]   = value[MAX_W-1:0];
      REG_BLUE_MAX:    level_max[2]   = value[MAX_W-1:0];
      REG_RED_SHIFT:   level_shift[0] = value[SHIFT_W-1:0];
      REG_GREEN_SHIFT: level_shift[1] = value[SHIFT_W-1:0];
      REG_BLUE_SHIFT:  level_shift[2] = value[SHIFT_W-1:0];
      REG_BIG_ENDIAN:  byte_swap      = value[0];
      REG_PIXEL_SIZE:  pixel_size     = value[1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [MAX_W-1:0] pick_max();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return MAX_W'(255);
      3:       return MAX_W'($urandom_range(1, 63));
      4:       return MAX_W'($urandom_range(256, 1023));
      default: return MAX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  always @(posedge clk) begin
    packed_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (packed_queue.size() == 0) begin
        report_mismatch("result with no pixel pending", out_packed_bytes, '0);
      end else begin
        want = packed_queue.pop_front();
        if (out_packed_bytes !== want.bytes)
          report_mismatch("packed_bytes", out_packed_bytes, want.bytes);
        if (out_byte_count !== want.count)
          report_mismatch("byte_count", 32'(out_byte_count), 32'(want.count));
      end
    end
  end

  task automatic load_register(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    note_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [LEVEL_W-1:0] red, input logic [LEVEL_W-1:0] green,
                            input logic [LEVEL_W-1:0] blue);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_red_level   <= red;
    in_green_level <= green;
    in_blue_level  <= blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    packed_queue.push_back(pack_pixel(red, green, blue));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (packed_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_format();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd1);
    send_pixel(8'd1, 8'd127, 8'd254);
    wait_idle();
  endtask

  task automatic test_pixel_sizes();
    for (int s = 0; s < 4; s++) begin
      for (int e = 0; e < 2; e++) begin
        load_register(REG_PIXEL_SIZE, 32'(s));
        load_register(REG_BIG_ENDIAN, 32'(e));
        send_pixel(8'd200 + 8'(s), 8'd99 + 8'(e), 8'd37);
        wait_idle();
      end
    end
  endtask

  task automatic test_scaling_extremes();
    // zero maximum, top shifts and overflow past bit 31
    load_register(REG_RED_MAX, 32'd0);
    load_register(REG_GREEN_MAX, 32'd65535);
    load_register(REG_BLUE_MAX, 32'd1);
    load_register(REG_RED_SHIFT, 32'd31);
    load_register(REG_GREEN_SHIFT, 32'd31);
    load_register(REG_BLUE_SHIFT, 32'd31);
    load_register(REG_PIXEL_SIZE, 32'(SIZE_32));
    load_register(REG_BIG_ENDIAN, 32'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd1, 8'd127);
    wait_idle();
    // 8-bit mode keeps only the low byte of the scaled red
    load_register(REG_RED_MAX, 32'd65535);
    load_register(REG_RED_SHIFT, 32'd7);
    load_register(REG_PIXEL_SIZE, 32'(SIZE_8));
    load_register(REG_BIG_ENDIAN, 32'd1);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd255, 8'd0);
    wait_idle();
  endtask

  task automatic test_random_sweep();
    for (int p = 0; p < SWEEP_PHASES; p++) begin
      idle_pct = (p == SWEEP_PHASES / 2) ? 0 : 20;
      load_register(REG_RED_MAX, ($urandom & 32'hFFFF_0000) | 32'(pick_max()));
      load_register(REG_GREEN_MAX, ($urandom & 32'hFFFF_0000) | 32'(pick_max()));
      load_register(REG_BLUE_MAX, ($urandom & 32'hFFFF_0000) | 32'(pick_max()));
      load_register(REG_RED_SHIFT, $urandom);
      load_register(REG_GREEN_SHIFT, $urandom);
      load_register(REG_BLUE_SHIFT, $urandom);
      load_register(REG_BIG_ENDIAN, $urandom);
      load_register(REG_PIXEL_SIZE, $urandom);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        send_pixel(pick_level(), pick_level(), pick_level());
      end
      wait_idle();
    end
    idle_pct = 20;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_format();
    test_pixel_sizes();
    test_scaling_extremes();
    test_random_sweep();
    if (mismatches == 0) begin
      $display("[rgb_pixel_format_packer_unit] OK");
    end else begin
      $display("[rgb_pixel_format_packer_unit] ERROR");
    end
    $finish;
  end

endmodule
